// ----- hdl/mmdc_pkg.sv -----
// Shared types, codes and constants of the masked minimum distance classifier.
package mmdc_pkg;

  localparam int MaxCategoriesDef = 16;
  localparam int NumFeaturesDef   = 28;

  localparam int MaskW  = 28;
  localparam int CountW = 5;
  localparam int AccW   = 48;
  localparam int LinkIdxW = 8;

  localparam logic [AccW-1:0] AccMax = {AccW{1'b1}};

  localparam logic [1:0] CmdLoad   = 2'd0;
  localparam logic [1:0] CmdRecord = 2'd1;
  localparam logic [1:0] CmdClear  = 2'd2;
  localparam logic [1:0] CmdSpare  = 2'd3;

  localparam logic [1:0] CfgMask  = 2'd0;
  localparam logic [1:0] CfgCount = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_WAIT,
    ST_SEARCH,
    ST_LABEL,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [3:0]         category;
    logic [4:0]         feature;
    logic signed [31:0] value;
    logic [31:0]        spread;
    logic [15:0]        class_id;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [15:0] predicted_id;
    logic [3:0]  predicted_index;
    logic        correct;
    logic [15:0] correct_count;
    logic        no_features;
  } result_t;

  typedef struct packed {
    logic            clear;
    logic            add;
    logic [AccW-1:0] term;
  } cell_ctrl_t;

  typedef struct packed {
    logic [AccW:0]     score;
    logic [LinkIdxW-1:0] idx;
  } link_t;

endpackage

// ----- hdl/mmdc_divider.sv -----
// Radix-2 restoring divider for one normalized distance term, one quotient bit a cycle.
module mmdc_divider import mmdc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [AccW-1:0] dividend_i,
  input  logic [31:0]     divisor_i,
  output logic            done_o,
  output logic [AccW-1:0] quotient_o
);

  localparam int StepW = $clog2(AccW + 1);

  logic [AccW-1:0]  dvd_q, dvd_d;
  logic [32:0]      rem_q, rem_d;
  logic [31:0]      dvs_q, dvs_d;
  logic [StepW-1:0] step_q, step_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [32:0]      rem_sh;

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    step_d = step_q;
    run_d  = run_q;
    done_d = 1'b0;
    rem_sh = {rem_q[31:0], dvd_q[AccW-1]};
    if (start_i) begin
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
      step_d = '0;
      run_d  = 1'b1;
    end else if (run_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sh - {1'b0, dvs_q};
        dvd_d = {dvd_q[AccW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        dvd_d = {dvd_q[AccW-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == StepW'(AccW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

// ----- hdl/mmdc_cell.sv -----
// One category cell: saturating distance accumulator and one stage of the minimum chain.
module mmdc_cell import mmdc_pkg::*; #(
  parameter int MAX_CATEGORIES = MaxCategoriesDef,
  parameter int IDX = 0,
  localparam int IdxW = $clog2(MAX_CATEGORIES),
  localparam int CntW = $clog2(MAX_CATEGORIES + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_ctrl_t      ctrl_i,
  input  logic [IdxW-1:0] target_i,
  input  logic [CntW-1:0] ncat_i,
  input  link_t           link_i,
  output link_t           link_o
);

  logic [AccW-1:0] acc_q, acc_d;
  logic [AccW:0]   sum;
  link_t           link_q, link_d;
  logic            active;

  assign sum    = {1'b0, acc_q} + {1'b0, ctrl_i.term};
  assign active = 32'(IDX) < 32'(ncat_i);

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.add && (32'(target_i) == 32'(IDX))) begin
      acc_d = sum[AccW] ? AccMax : sum[AccW-1:0];
    end
  end

  always_comb begin
    link_d = link_i;
    if (active && ({1'b0, acc_q} < link_i.score)) begin
      link_d.score = {1'b0, acc_q};
      link_d.idx   = LinkIdxW'(IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    link_q <= link_d;
  end

  assign link_o = link_q;

endmodule

// ----- hdl/masked_min_distance_classifier.sv -----
// Top level of the masked minimum distance classifier.
// Commands are taken when start_i is high and busy_o low. Load and clear items leave the
// block idle. A record feature that is masked in runs one shared 48-step divider per
// compared category in turn; the last feature then keeps the block busy for the minimum
// chain walk and label read, and the result shows in the cycle after. The result shows
// for exactly one cycle with res_valid_o high and cannot be held off. Configuration
// writes are always ready; write them only while the block is idle.
module masked_min_distance_classifier import mmdc_pkg::*; #(
  parameter int MAX_CATEGORIES = MaxCategoriesDef,
  parameter int NUM_FEATURES   = NumFeaturesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  item_t       item_i,
  output logic        res_valid_o,
  output result_t     res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int IdxW   = $clog2(MAX_CATEGORIES);
  localparam int CntW   = $clog2(MAX_CATEGORIES + 1);
  localparam int Depth  = MAX_CATEGORIES * NUM_FEATURES;
  localparam int AddrW  = $clog2(Depth);
  localparam int SrchW  = $clog2(MAX_CATEGORIES + 2);

  state_e state_q, state_d;

  logic [MaskW-1:0]  mask_q;
  logic [CountW-1:0] count_q;
  logic [IdxW-1:0]   cat_q, cat_d;
  logic [4:0]        feat_q;
  logic signed [31:0] val_q;
  logic [15:0]       cid_q;
  logic              last_q;
  logic [SrchW-1:0]  srch_q, srch_d;
  logic [IdxW-1:0]   best_q;
  logic [15:0]       hit_q, hit_d;
  logic              rvalid_q;
  result_t           res_q, res_d;

  logic [31:0] mean_mem [Depth];
  logic [31:0] spread_mem [Depth];
  logic [15:0] label_mem [MAX_CATEGORIES];
  logic [31:0] mean_rd_q, spread_rd_q;
  logic [15:0] label_rd_q;

  logic            accept, is_load, is_rec, is_clr;
  logic            feat_on, empty, last_cat;
  logic [CntW-1:0] ncat;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [32:0]     diff, absd;
  logic            div_start, div_done;
  logic [AccW-1:0] quotient;
  cell_ctrl_t      ctrl;
  link_t           chain [MAX_CATEGORIES + 1];
  logic [15:0]     pid;
  logic            ok;

  assign accept  = start_i && !busy_o;
  assign is_load = item_i.cmd == CmdLoad;
  assign is_rec  = item_i.cmd == CmdRecord;
  assign is_clr  = item_i.cmd == CmdClear;
  assign busy_o  = state_q != ST_IDLE;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (count_q == '0) begin
      ncat = CntW'(1);
    end else if (32'(count_q) > 32'(MAX_CATEGORIES)) begin
      ncat = CntW'(MAX_CATEGORIES);
    end else begin
      ncat = CntW'(count_q);
    end
  end

  always_comb begin
    feat_on = 1'b0;
    if ((32'(item_i.feature) < 32'(NUM_FEATURES)) && (32'(item_i.feature) < MaskW)) begin
      feat_on = mask_q[item_i.feature];
    end
  end

  always_comb begin
    empty = 1'b1;
    for (int f = 0; f < MaskW; f++) begin
      if ((f < NUM_FEATURES) && mask_q[f]) begin
        empty = 1'b0;
      end
    end
  end

  assign last_cat = 32'(cat_q) == (32'(ncat) - 32'd1);
  assign wr_addr  = AddrW'(32'(item_i.category) * NUM_FEATURES + 32'(item_i.feature));
  assign rd_addr  = AddrW'(32'(cat_q) * NUM_FEATURES + 32'(feat_q));

  always_ff @(posedge clk_i) begin
    if (accept && is_load && (32'(item_i.category) < 32'(MAX_CATEGORIES))
        && (32'(item_i.feature) < 32'(NUM_FEATURES))) begin
      mean_mem[wr_addr]   <= item_i.value;
      spread_mem[wr_addr] <= item_i.spread;
      label_mem[IdxW'(item_i.category)] <= item_i.class_id;
    end
    mean_rd_q   <= mean_mem[rd_addr];
    spread_rd_q <= spread_mem[rd_addr];
    label_rd_q  <= label_mem[best_q];
  end

  assign diff = {val_q[31], val_q} - {mean_rd_q[31], mean_rd_q};
  assign absd = diff[32] ? (33'd0 - diff) : diff;

  mmdc_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({absd[31:0], 16'h0000}),
    .divisor_i  (spread_rd_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign chain[0] = '{score: {1'b1, {AccW{1'b0}}}, idx: '0};

  for (genvar i = 0; i < MAX_CATEGORIES; i++) begin : g_cell
    mmdc_cell #(
      .MAX_CATEGORIES (MAX_CATEGORIES),
      .IDX            (i)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .target_i (cat_q),
      .ncat_i   (ncat),
      .link_i   (chain[i]),
      .link_o   (chain[i + 1])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && is_rec) begin
          if (feat_on) begin
            state_d = ST_READ;
          end else if (item_i.last) begin
            state_d = ST_SEARCH;
          end
        end
      end
      ST_READ:   state_d = ST_DIV;
      ST_DIV:    state_d = ST_WAIT;
      ST_WAIT: begin
        if (div_done) begin
          if (!last_cat) begin
            state_d = ST_READ;
          end else if (last_q) begin
            state_d = ST_SEARCH;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SEARCH: begin
        if (32'(srch_q) == 32'(MAX_CATEGORIES)) begin
          state_d = ST_LABEL;
        end
      end
      ST_LABEL:  state_d = ST_OUT;
      ST_OUT:    state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    ctrl      = '{clear: 1'b0, add: 1'b0, term: '0};
    cat_d     = cat_q;
    srch_d    = '0;
    unique case (state_q)
      ST_IDLE:   cat_d = '0;
      ST_DIV:    div_start = 1'b1;
      ST_WAIT: begin
        if (div_done) begin
          ctrl.add  = 1'b1;
          ctrl.term = (spread_rd_q == '0) ? AccMax : quotient;
          cat_d     = cat_q + 1'b1;
        end
      end
      ST_SEARCH: srch_d = srch_q + 1'b1;
      ST_OUT:    ctrl.clear = 1'b1;
      default: begin
      end
    endcase
  end

  always_comb begin
    pid   = empty ? 16'h0000 : label_rd_q;
    ok    = !empty && (label_rd_q == cid_q);
    hit_d = hit_q;
    if (accept && is_clr) begin
      hit_d = '0;
    end else if ((state_q == ST_OUT) && ok && (hit_q != 16'hFFFF)) begin
      hit_d = hit_q + 16'd1;
    end
    res_d.predicted_id    = pid;
    res_d.predicted_index = empty ? 4'd0 : 4'(best_q);
    res_d.correct         = ok;
    res_d.correct_count   = hit_d;
    res_d.no_features     = empty;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mask_q   <= {MaskW{1'b1}};
      count_q  <= CountW'(16);
      cat_q    <= '0;
      srch_q   <= '0;
      hit_q    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cat_q    <= cat_d;
      srch_q   <= srch_d;
      hit_q    <= hit_d;
      rvalid_q <= state_q == ST_OUT;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgMask) begin
          mask_q <= cfg_data_i[MaskW-1:0];
        end else if (cfg_index_i == CfgCount) begin
          count_q <= cfg_data_i[CountW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_rec) begin
      feat_q <= item_i.feature;
      val_q  <= item_i.value;
      cid_q  <= item_i.class_id;
      last_q <= item_i.last;
    end
    if (state_q == ST_SEARCH) begin
      best_q <= IdxW'(chain[MAX_CATEGORIES].idx);
    end
    if (state_q == ST_OUT) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = rvalid_q;
  assign res_o       = res_q;

endmodule
